// File: rtl/periodic_send_scheduler_defines.svh
// Assertion macros shared by the periodic send scheduler checkers.
// Depends on nothing; included by the checker file.
`ifndef PERIODIC_SEND_SCHEDULER_DEFINES_SVH
`define PERIODIC_SEND_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pss_pkg.sv
// Shared types and constants for the periodic send scheduler.
// Depends on nothing; used by the interfaces, the top level, the engine and the checker.
`timescale 1ns / 1ps

package pss_pkg;

    // Table size and derived widths.
    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths.
    localparam int OP_W   = 2;
    localparam int ID_W   = 16;
    localparam int PER_W  = 16;
    localparam int TIME_W = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PER_W-1:0]  per;
        logic [TIME_W-1:0] next_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One result beat.
    typedef struct packed {
        logic [ID_W-1:0] chosen_id;
        logic            table_empty;
    } result_t;

endpackage

// File: rtl/pss_in_if.sv
// Input channel of the periodic send scheduler: valid/ready plus one request.
// Depends on pss_pkg.
`timescale 1ns / 1ps

interface pss_in_if;
    logic                        valid;
    logic                        ready;
    logic [pss_pkg::OP_W-1:0]    operation;
    logic [pss_pkg::ID_W-1:0]    user_id;
    logic [pss_pkg::PER_W-1:0]   period;

    modport source (output valid, operation, user_id, period, input ready);
    modport sink   (input valid, operation, user_id, period, output ready);
endinterface

// File: rtl/pss_out_if.sv
// Output channel of the periodic send scheduler: valid/ready plus one result.
// Depends on pss_pkg.
`timescale 1ns / 1ps

interface pss_out_if;
    logic                      valid;
    logic                      ready;
    logic [pss_pkg::ID_W-1:0]  chosen_id;
    logic                      table_empty;

    modport source (output valid, chosen_id, table_empty, input ready);
    modport sink   (input valid, chosen_id, table_empty, output ready);
endinterface

// File: rtl/periodic_send_scheduler.sv
// Periodic send scheduler, top level. Depends on pss_pkg, pss_in_if, pss_out_if, pss_engine.
// Clear and load requests leave the engine idle. A next request on a table of N entries
// occupies the engine through a scan (one memory read per entry through a single
// comparator), one write-back and one handoff; an empty table goes straight to handoff.
// The result appears on the output in the cycle after handoff, and is held there while
// the engine takes the next request. Reset empties the table at once; no memory pass.
`timescale 1ns / 1ps

module periodic_send_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    pss_in_if.sink     in_ch,
    pss_out_if.source  out_ch
);

    logic             res_valid;
    logic             res_ready;
    pss_pkg::result_t res;

    logic             out_valid_reg;
    pss_pkg::result_t out_data_reg;
    logic             take;

    pss_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // The output register takes a new beat when empty or being drained.
    assign take      = !out_valid_reg || out_ch.ready;
    assign res_ready = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else if (take)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
            begin
                out_data_reg <= res;
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.chosen_id   = out_data_reg.chosen_id;
    assign out_ch.table_empty = out_data_reg.table_empty;

endmodule

// File: rtl/pss_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/pss_engine.sv
// Scheduler engine: handles clear and load requests and scans the entry
// memory for the earliest next send. Depends on pss_pkg, pss_in_if, pss_ram.
`timescale 1ns / 1ps

module pss_engine (
    input  logic             clk,
    input  logic             rst_n,
    pss_in_if.sink           in_ch,
    output logic             res_valid,
    input  logic             res_ready,
    output pss_pkg::result_t res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [pss_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [pss_pkg::CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [pss_pkg::IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [pss_pkg::IDX_W-1:0]       best_idx_reg, best_idx_next;
    pss_pkg::entry_t                 best_reg, best_next;
    pss_pkg::result_t                res_reg, res_next;

    logic                            ram_wr_en;
    logic [pss_pkg::IDX_W-1:0]       ram_wr_addr;
    pss_pkg::entry_t                 ram_wr_data;
    logic                            ram_rd_en;
    logic [pss_pkg::IDX_W-1:0]       ram_rd_addr;
    pss_pkg::entry_t                 ram_rd_data;

    // True when entry a is due before entry b, or at the same time with a lower id.
    function automatic logic entry_better(pss_pkg::entry_t a, pss_pkg::entry_t b);
        return (a.next_time < b.next_time) ||
               ((a.next_time == b.next_time) && (a.id < b.id));
    endfunction

    // Advance a next time by a period, saturating at the top of the range.
    function automatic logic [pss_pkg::TIME_W-1:0] sat_add(
        logic [pss_pkg::TIME_W-1:0] t,
        logic [pss_pkg::PER_W-1:0]  p
    );
        logic [pss_pkg::TIME_W:0] sum;
        sum = {1'b0, t} + (pss_pkg::TIME_W + 1)'(p);
        return sum[pss_pkg::TIME_W] ? '1 : sum[pss_pkg::TIME_W-1:0];
    endfunction

    pss_ram #(
        .WIDTH(pss_pkg::ENTRY_W),
        .DEPTH(pss_pkg::MAX_ENTRIES)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign res_valid   = (state_reg == ST_DONE);
    assign res         = res_reg;

    // Next-state logic and memory port control.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        res_next      = res_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = best_idx_reg;
        ram_wr_data   = best_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = rd_idx_reg[pss_pkg::IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    case (in_ch.operation)
                        pss_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        pss_pkg::OP_LOAD:
                        begin
                            // A load into a full table is dropped.
                            if (count_reg < pss_pkg::CNT_W'(pss_pkg::MAX_ENTRIES))
                            begin
                                ram_wr_en             = 1'b1;
                                ram_wr_addr           = count_reg[pss_pkg::IDX_W-1:0];
                                ram_wr_data.id        = in_ch.user_id;
                                ram_wr_data.per       = in_ch.period;
                                ram_wr_data.next_time = pss_pkg::TIME_W'(in_ch.period);
                                count_next            = count_reg + 1'b1;
                            end
                        end
                        pss_pkg::OP_NEXT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.chosen_id   = '0;
                                res_next.table_empty = 1'b1;
                                state_next           = ST_DONE;
                            end
                            else
                            begin
                                // Fetch entry zero; the scan starts next cycle.
                                ram_rd_en    = 1'b1;
                                ram_rd_addr  = '0;
                                rd_idx_next  = pss_pkg::CNT_W'(1);
                                cmp_idx_next = '0;
                                state_next   = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Keep one read in flight ahead of the comparison.
                if (rd_idx_reg < count_reg)
                begin
                    ram_rd_en   = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                // Strict comparison keeps the earliest position on a full tie.
                if ((cmp_idx_reg == '0) || entry_better(ram_rd_data, best_reg))
                begin
                    best_next     = ram_rd_data;
                    best_idx_next = cmp_idx_reg;
                end
                cmp_idx_next = cmp_idx_reg + 1'b1;
                if ((pss_pkg::CNT_W'(cmp_idx_reg) + pss_pkg::CNT_W'(1)) == count_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                // Write the winner back with its advanced next time.
                ram_wr_en             = 1'b1;
                ram_wr_addr           = best_idx_reg;
                ram_wr_data           = best_reg;
                ram_wr_data.next_time = sat_add(best_reg.next_time, best_reg.per);
                res_next.chosen_id    = best_reg.id;
                res_next.table_empty  = 1'b0;
                state_next            = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            cmp_idx_reg  <= '0;
            best_idx_reg <= '0;
            best_reg     <= '0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            cmp_idx_reg  <= cmp_idx_next;
            best_idx_reg <= best_idx_next;
            best_reg     <= best_next;
            res_reg      <= res_next;
        end
    end

endmodule

// File: rtl/pss_checker.sv
// Port-level checks for the periodic send scheduler, bound to the top level.
// Depends on pss_pkg and periodic_send_scheduler_defines.svh.
`timescale 1ns / 1ps
`include "periodic_send_scheduler_defines.svh"

module pss_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [pss_pkg::OP_W-1:0]   in_operation,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [pss_pkg::ID_W-1:0]   chosen_id,
    input logic                       table_empty
);

    // A stalled result beat stays offered.
    `PSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output beat dropped while stalled")

    // A stalled result beat keeps its id.
    `PSS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(chosen_id), "chosen_id changed while stalled")

    // An empty-table answer carries id zero.
    `PSS_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && table_empty, chosen_id == '0, "empty result with nonzero id")

    // A next request occupies the engine, so no beat is taken right after it.
    `PSS_ASSERT_NEXT(a_next_busy, clk, rst_n, in_valid && in_ready && (in_operation == pss_pkg::OP_NEXT), !in_ready, "input ready right after a next request")

endmodule

bind periodic_send_scheduler pss_checker u_pss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_operation(in_ch.operation),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .chosen_id   (out_ch.chosen_id),
    .table_empty (out_ch.table_empty)
);
